>>> hdl/hsvrgb_pkg.sv
package hsvrgb_pkg;

    localparam int unsigned FULL_SCALE  = 255;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned FULL_DEN    = FULL_SCALE << FRAC_BITS;
    localparam int unsigned HALF_DEN    = FULL_SCALE << (FRAC_BITS - 1);
    localparam int unsigned ROUND_P     = FULL_SCALE / 2;
    localparam int unsigned RECIP_255   = 32'h0000_8081;
    localparam int unsigned RECIP_SHIFT = 23;

    typedef enum logic [2:0] {
        SECTOR_RED     = 3'd0,
        SECTOR_YELLOW  = 3'd1,
        SECTOR_GREEN   = 3'd2,
        SECTOR_CYAN    = 3'd3,
        SECTOR_BLUE    = 3'd4,
        SECTOR_MAGENTA = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } t_hsv_beat;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_beat;

    typedef struct packed {
        t_sector     sector;
        logic [7:0]  v;
        logic [7:0]  p;
        logic [23:0] fq;
        logic [23:0] ft;
    } t_mid_beat;

    typedef struct packed {
        t_sector    sector;
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } t_lvl_beat;

endpackage

>>> hdl/hsvrgb_front.sv
module hsvrgb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  hsvrgb_pkg::t_hsv_beat i_hsv,
    output logic                  o_valid,
    output hsvrgb_pkg::t_mid_beat o_mid
);

    logic [18:0] n_scaled;
    logic [15:0] n_pv;
    logic [16:0] n_frac_inv;
    logic [24:0] n_ft;
    logic [15:0] n_pv_round;
    logic [31:0] n_pprod;

    logic                 r1_valid;
    hsvrgb_pkg::t_sector  r1_sector;
    logic [15:0]          r1_frac;
    logic [7:0]           r1_s;
    logic [7:0]           r1_v;
    logic [15:0]          r1_pv;

    logic                 r2_valid;
    hsvrgb_pkg::t_sector  r2_sector;
    logic [7:0]           r2_v;
    logic [23:0]          r2_fq;
    logic [23:0]          r2_ft;
    logic [31:0]          r2_pprod;

    assign n_scaled = {1'b0, i_hsv.hue, 2'b00} + {2'b00, i_hsv.hue, 1'b0};
    assign n_pv     = i_hsv.brightness * (8'(hsvrgb_pkg::FULL_SCALE) - i_hsv.saturation);

    assign n_frac_inv = 17'h1_0000 - {1'b0, r1_frac};
    assign n_ft       = n_frac_inv * r1_s;
    assign n_pv_round = r1_pv + 16'(hsvrgb_pkg::ROUND_P);
    assign n_pprod    = n_pv_round * 16'(hsvrgb_pkg::RECIP_255);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_sector <= hsvrgb_pkg::t_sector'(n_scaled[18:16]);
            r1_frac   <= n_scaled[15:0];
            r1_s      <= i_hsv.saturation;
            r1_v      <= i_hsv.brightness;
            r1_pv     <= n_pv;
            r2_sector <= r1_sector;
            r2_v      <= r1_v;
            r2_fq     <= r1_frac * r1_s;
            r2_ft     <= n_ft[23:0];
            r2_pprod  <= n_pprod;
        end
    end

    assign o_valid      = r2_valid;
    assign o_mid.sector = r2_sector;
    assign o_mid.v      = r2_v;
    assign o_mid.p      = r2_pprod[hsvrgb_pkg::RECIP_SHIFT +: 8];
    assign o_mid.fq     = r2_fq;
    assign o_mid.ft     = r2_ft;

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid |-> (r1_sector <= hsvrgb_pkg::SECTOR_MAGENTA))
        else $error("sector out of range");

    a_p_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid |-> (r2_pprod[31:hsvrgb_pkg::RECIP_SHIFT] <= {1'b0, r2_v}))
        else $error("p exceeds brightness");

endmodule

>>> hdl/hsvrgb_levels.sv
module hsvrgb_levels (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  hsvrgb_pkg::t_mid_beat i_mid,
    output logic                  o_valid,
    output hsvrgb_pkg::t_lvl_beat o_lvl
);

    logic [23:0] n_dq;
    logic [23:0] n_dt;
    logic [31:0] n_sum_q;
    logic [31:0] n_sum_t;

    logic                r3_valid;
    hsvrgb_pkg::t_sector r3_sector;
    logic [7:0]          r3_v;
    logic [7:0]          r3_p;
    logic [31:0]         r3_nq;
    logic [31:0]         r3_nt;

    logic                r4_valid;
    hsvrgb_pkg::t_sector r4_sector;
    logic [7:0]          r4_v;
    logic [7:0]          r4_p;
    logic [31:0]         r4_qprod;
    logic [31:0]         r4_tprod;

    assign n_dq = 24'(hsvrgb_pkg::FULL_DEN) - i_mid.fq;
    assign n_dt = 24'(hsvrgb_pkg::FULL_DEN) - i_mid.ft;

    assign n_sum_q = r3_nq + 32'(hsvrgb_pkg::HALF_DEN);
    assign n_sum_t = r3_nt + 32'(hsvrgb_pkg::HALF_DEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_sector <= i_mid.sector;
            r3_v      <= i_mid.v;
            r3_p      <= i_mid.p;
            r3_nq     <= i_mid.v * n_dq;
            r3_nt     <= i_mid.v * n_dt;
            r4_sector <= r3_sector;
            r4_v      <= r3_v;
            r4_p      <= r3_p;
            r4_qprod  <= n_sum_q[31:16] * 16'(hsvrgb_pkg::RECIP_255);
            r4_tprod  <= n_sum_t[31:16] * 16'(hsvrgb_pkg::RECIP_255);
        end
    end

    assign o_valid      = r4_valid;
    assign o_lvl.sector = r4_sector;
    assign o_lvl.v      = r4_v;
    assign o_lvl.p      = r4_p;
    assign o_lvl.q      = r4_qprod[hsvrgb_pkg::RECIP_SHIFT +: 8];
    assign o_lvl.t      = r4_tprod[hsvrgb_pkg::RECIP_SHIFT +: 8];

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid |-> (r4_qprod[31:hsvrgb_pkg::RECIP_SHIFT] <= {1'b0, r4_v}))
        else $error("q exceeds brightness");

    a_t_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid |-> (r4_tprod[31:hsvrgb_pkg::RECIP_SHIFT] <= {1'b0, r4_v}))
        else $error("t exceeds brightness");

endmodule

>>> hdl/hsvrgb_route.sv
module hsvrgb_route (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  hsvrgb_pkg::t_lvl_beat i_lvl,
    output logic                  o_valid,
    output hsvrgb_pkg::t_rgb_beat o_rgb
);

    hsvrgb_pkg::t_rgb_beat n_rgb;
    hsvrgb_pkg::t_rgb_beat r_rgb;
    logic                  r_valid;

    always_comb begin
        case (i_lvl.sector)
            hsvrgb_pkg::SECTOR_RED: begin
                n_rgb = '{red: i_lvl.v, green: i_lvl.t, blue: i_lvl.p};
            end
            hsvrgb_pkg::SECTOR_YELLOW: begin
                n_rgb = '{red: i_lvl.q, green: i_lvl.v, blue: i_lvl.p};
            end
            hsvrgb_pkg::SECTOR_GREEN: begin
                n_rgb = '{red: i_lvl.p, green: i_lvl.v, blue: i_lvl.t};
            end
            hsvrgb_pkg::SECTOR_CYAN: begin
                n_rgb = '{red: i_lvl.p, green: i_lvl.q, blue: i_lvl.v};
            end
            hsvrgb_pkg::SECTOR_BLUE: begin
                n_rgb = '{red: i_lvl.t, green: i_lvl.p, blue: i_lvl.v};
            end
            default: begin
                n_rgb = '{red: i_lvl.v, green: i_lvl.p, blue: i_lvl.q};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

    a_v_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_valid) |=> (r_rgb.red == $past(i_lvl.v) || r_rgb.green == $past(i_lvl.v)
                                || r_rgb.blue == $past(i_lvl.v)))
        else $error("brightness missing from routed pixel");

endmodule

>>> hdl/hsv_to_rgb_converter.sv
// Channel   Ports                              Beat
// input     i_hsv, i_hsv_valid, o_hsv_ready    hue 16b, saturation 8b, brightness 8b
// output    o_rgb, o_rgb_valid, i_rgb_ready    red 8b, green 8b, blue 8b
//
// One pixel can enter every clock while the output is not stalled; each beat passes
// through five register stages: four hold one multiplier level each,
// and the last holds the sector routing of the levels to red, green and blue.
// Reset is synchronous and clears only the stage valid bits.
// When the output beat is not taken, all stages hold and the input is not ready.
module hsv_to_rgb_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvrgb_pkg::t_hsv_beat i_hsv,
    input  logic                  i_hsv_valid,
    output logic                  o_hsv_ready,
    output hsvrgb_pkg::t_rgb_beat o_rgb,
    output logic                  o_rgb_valid,
    input  logic                  i_rgb_ready
);

    logic                  adv;
    logic                  mid_valid;
    logic                  lvl_valid;
    hsvrgb_pkg::t_mid_beat mid;
    hsvrgb_pkg::t_lvl_beat lvl;

    assign adv         = !o_rgb_valid || i_rgb_ready;
    assign o_hsv_ready = adv;

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_hsv_valid),
        .i_hsv   (i_hsv),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    hsvrgb_levels u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .o_valid (lvl_valid),
        .o_lvl   (lvl)
    );

    hsvrgb_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (lvl_valid),
        .i_lvl   (lvl),
        .o_valid (o_rgb_valid),
        .o_rgb   (o_rgb)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb_valid && !i_rgb_ready) |-> !o_hsv_ready)
        else $error("input taken while output stalled");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb_valid && !i_rgb_ready) |=> ($stable(lvl_valid) && $stable(mid_valid)))
        else $error("pipeline moved during stall");

endmodule
